/* rtl/rlpe_pkg.sv */
// Shared types and constants for the RGB LED serial pulse encoder.
`default_nettype none

package rlpe_pkg;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int PIXEL_BITS    = 24;
   localparam int COUNT_BITS    = 5;

   localparam logic [COUNT_BITS-1:0] BITS_PER_PIXEL = 5'd24;

   // Register indexes on the csr port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_ZERO_HIGH = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ZERO_LOW  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ONE_HIGH  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ONE_LOW   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LATCH     = 3'd4;

   // Register reset values.
   localparam logic [CSR_DATA_BITS-1:0] RST_ZERO_HIGH = 16'd20;
   localparam logic [CSR_DATA_BITS-1:0] RST_ZERO_LOW  = 16'd42;
   localparam logic [CSR_DATA_BITS-1:0] RST_ONE_HIGH  = 16'd40;
   localparam logic [CSR_DATA_BITS-1:0] RST_ONE_LOW   = 16'd22;
   localparam logic [CSR_DATA_BITS-1:0] RST_LATCH     = 16'd2500;

   // Command codes.
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_OFFER = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic can_accept;
      logic refused;
      logic underrun;
   } rsp_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] zero_high_ticks;
      logic [CSR_DATA_BITS-1:0] zero_low_ticks;
      logic [CSR_DATA_BITS-1:0] one_high_ticks;
      logic [CSR_DATA_BITS-1:0] one_low_ticks;
      logic [CSR_DATA_BITS-1:0] latch_ticks;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/rlpe_chan_if.sv */
// Valid/ready channel carrying one payload per beat.
`default_nettype none

interface rlpe_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/rgb_led_serial_pulse_encoder.sv */
// Top level: single-wire RGB LED pulse encoder with input and result registers.
// Req beat to rsp beat passes the input register, then the result register.
// Throughput: one beat per cycle unless rsp stalls; state update is a single pass.
// Backpressure on rsp stalls the result register, then the input register.
// Reset: synchronous, active high; buffer empty, line low, latch gap counted as met,
// timing registers back to their defaults.
`default_nettype none

module rgb_led_serial_pulse_encoder #(
   parameter int TIMER_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   rlpe_chan_if.sink                                 req_bus,
   rlpe_chan_if.source                               rsp_bus,
   input  wire logic                                 csr_we,
   input  wire logic [rlpe_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [rlpe_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import rlpe_pkg::*;

   cfg_type cfg;

   // Input register stage.
   logic    req_vld_ff;
   req_type req_ff;

   // Result register stage.
   logic    rsp_vld_ff;
   rsp_type rsp_ff;

   rsp_type core_rsp;
   logic    advance;   // result register free or draining this cycle
   logic    step;      // buffered beat goes through the encoder now

   assign advance = !rsp_vld_ff || rsp_bus.ready;
   assign step    = req_vld_ff && advance;

   // Input stage takes a beat when empty or when its beat moves on.
   assign req_bus.ready = !req_vld_ff || advance;

   rlpe_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rlpe_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_ff),
      .cfg    (cfg),
      .result (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_bus.ready) begin
         req_vld_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         req_ff <= req_bus.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_bus.valid   = rsp_vld_ff;
   assign rsp_bus.payload = rsp_ff;

   a_stall_holds_req: assert property (@(posedge clock) disable iff (reset)
      (req_vld_ff && !advance) |=> req_vld_ff)
      else $error("buffered beat lost during stall");

   a_step_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_vld_ff)
      else $error("processed beat produced no result");

   a_no_refuse_on_tick: assert property (@(posedge clock) disable iff (reset)
      (step && req_ff.cmd == CMD_TICK) |-> !core_rsp.refused)
      else $error("refusal flagged on a tick");

endmodule

`default_nettype wire

/* rtl/rlpe_cfg.sv */
// Timing register file written through the csr port.
`default_nettype none

module rlpe_cfg (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [rlpe_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [rlpe_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output rlpe_pkg::cfg_type                         cfg
);
   import rlpe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ZERO_HIGH: cfg_in.zero_high_ticks = csr_wdata;
            CSR_ZERO_LOW:  cfg_in.zero_low_ticks  = csr_wdata;
            CSR_ONE_HIGH:  cfg_in.one_high_ticks  = csr_wdata;
            CSR_ONE_LOW:   cfg_in.one_low_ticks   = csr_wdata;
            CSR_LATCH:     cfg_in.latch_ticks     = csr_wdata;
            default:       cfg_in = cfg_ff;  // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_high_ticks <= RST_ZERO_HIGH;
         cfg_ff.zero_low_ticks  <= RST_ZERO_LOW;
         cfg_ff.one_high_ticks  <= RST_ONE_HIGH;
         cfg_ff.one_low_ticks   <= RST_ONE_LOW;
         cfg_ff.latch_ticks     <= RST_LATCH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/rlpe_core.sv */
// Encoder state: holding buffer, bit shifter, phase and gap timers.
`default_nettype none

module rlpe_core #(
   parameter int TIMER_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire rlpe_pkg::req_type item,
   input  wire rlpe_pkg::cfg_type cfg,
   output rlpe_pkg::rsp_type      result
);
   import rlpe_pkg::*;

   localparam int CW = (TIMER_BITS > CSR_DATA_BITS) ? TIMER_BITS : CSR_DATA_BITS;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
   localparam logic [CW-1:0]         TIMER_MAX_W = CW'(TIMER_MAX);

   // Register length saturated into the timer range; zero acts as one tick.
   function automatic logic [TIMER_BITS-1:0] clamp_len(input logic [CSR_DATA_BITS-1:0] v);
      logic [CW-1:0] e;
      e = CW'(v);
      return (e > TIMER_MAX_W) ? TIMER_MAX : TIMER_BITS'(e);
   endfunction

   logic [PIXEL_BITS-1:0] shifter_ff,  shifter_in;
   logic [COUNT_BITS-1:0] bits_ff,     bits_in;
   logic                  high_ff,     high_in;
   logic [TIMER_BITS-1:0] phase_ff,    phase_in;
   logic [PIXEL_BITS-1:0] held_ff,     held_in;
   logic                  held_vld_ff, held_vld_in;
   logic                  held_last_ff, held_last_in;
   logic                  send_last_ff, send_last_in;
   logic                  in_frame_ff, in_frame_in;
   logic [TIMER_BITS-1:0] gap_ff,      gap_in;

   logic load;
   logic refused;
   logic underrun;
   logic gap_met;

   assign gap_met = (CW'(gap_ff) >= CW'(cfg.latch_ticks)) || (gap_ff == TIMER_MAX);

   always_comb begin
      shifter_in   = shifter_ff;
      bits_in      = bits_ff;
      high_in      = high_ff;
      phase_in     = phase_ff;
      held_in      = held_ff;
      held_vld_in  = held_vld_ff;
      held_last_in = held_last_ff;
      send_last_in = send_last_ff;
      in_frame_in  = in_frame_ff;
      gap_in       = gap_ff;
      load         = 1'b0;
      refused      = 1'b0;
      underrun     = 1'b0;

      if (step) begin
         if (item.cmd == CMD_OFFER) begin
            if (held_vld_ff) begin
               refused = 1'b1;
            end else begin
               held_in      = {item.green, item.red, item.blue};
               held_last_in = item.frame_last;
               held_vld_in  = 1'b1;
            end
         end else if (bits_ff == '0) begin
            // idle between pixels
            if (in_frame_ff) begin
               load = held_vld_ff;
            end else if (held_vld_ff && gap_met) begin
               load = 1'b1;
            end else if (gap_ff != TIMER_MAX) begin
               gap_in = gap_ff + 1'b1;
            end
         end else if (phase_ff <= TIMER_BITS'(1)) begin
            if (high_ff) begin
               high_in  = 1'b0;
               phase_in = clamp_len(shifter_ff[PIXEL_BITS-1] ? cfg.one_low_ticks
                                                             : cfg.zero_low_ticks);
            end else begin
               shifter_in = {shifter_ff[PIXEL_BITS-2:0], 1'b0};
               bits_in    = bits_ff - 1'b1;
               if (bits_ff != COUNT_BITS'(1)) begin
                  high_in  = 1'b1;
                  phase_in = clamp_len(shifter_ff[PIXEL_BITS-2] ? cfg.one_high_ticks
                                                                : cfg.zero_high_ticks);
               end else begin
                  // pixel done
                  high_in  = 1'b0;
                  phase_in = '0;
                  if (send_last_ff) begin
                     in_frame_in = 1'b0;
                     gap_in      = '0;
                  end else if (held_vld_ff) begin
                     load = 1'b1;
                  end else begin
                     underrun = 1'b1;
                  end
               end
            end
         end else begin
            phase_in = phase_ff - 1'b1;
         end

         if (load) begin
            shifter_in   = held_ff;
            send_last_in = held_last_ff;
            held_vld_in  = 1'b0;
            bits_in      = BITS_PER_PIXEL;
            in_frame_in  = 1'b1;
            high_in      = 1'b1;
            phase_in     = clamp_len(held_ff[PIXEL_BITS-1] ? cfg.one_high_ticks
                                                           : cfg.zero_high_ticks);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shifter_ff   <= '0;
         bits_ff      <= '0;
         high_ff      <= 1'b0;
         phase_ff     <= '0;
         held_vld_ff  <= 1'b0;
         held_last_ff <= 1'b0;
         send_last_ff <= 1'b0;
         in_frame_ff  <= 1'b0;
         gap_ff       <= TIMER_MAX;
      end else begin
         shifter_ff   <= shifter_in;
         bits_ff      <= bits_in;
         high_ff      <= high_in;
         phase_ff     <= phase_in;
         held_vld_ff  <= held_vld_in;
         held_last_ff <= held_last_in;
         send_last_ff <= send_last_in;
         in_frame_ff  <= in_frame_in;
         gap_ff       <= gap_in;
      end
   end

   // pixel buffer itself is payload, no reset
   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   assign result.line_level = (bits_in != '0) && high_in;
   assign result.can_accept = !held_vld_in;
   assign result.refused    = refused;
   assign result.underrun   = underrun;

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= BITS_PER_PIXEL)
      else $error("bit count above pixel size");

   a_high_needs_bits: assert property (@(posedge clock) disable iff (reset)
      high_ff |-> (bits_ff != '0))
      else $error("high phase with no bit in flight");

   a_bits_in_frame: assert property (@(posedge clock) disable iff (reset)
      (bits_ff != '0) |-> in_frame_ff)
      else $error("sending outside a frame");

   a_refuse_keeps: assert property (@(posedge clock) disable iff (reset)
      (step && item.cmd == CMD_OFFER && held_vld_ff) |=> held_vld_ff)
      else $error("refused offer disturbed the buffer");

endmodule

`default_nettype wire

/* test/rlpe_line_checker.sv */
// Checker for the pulse encoder: mirrors the line timing and compares each result beat.
module rlpe_line_checker
   import rlpe_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_fire,
   input  req_type                  req_beat,
   input  logic                     rsp_fire,
   input  rsp_type                  rsp_beat,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       mismatch_count,
   output int                       open_count
);

   localparam logic [CSR_DATA_BITS-1:0] GAP_SATURATED = '1;
   localparam int                       REPORT_LIMIT  = 10;

   cfg_type                  timing;
   logic [PIXEL_BITS-1:0]    shifter;
   logic [PIXEL_BITS-1:0]    held_grb;
   logic [COUNT_BITS-1:0]    bits_left;
   logic [CSR_DATA_BITS-1:0] phase_cnt;
   logic [CSR_DATA_BITS-1:0] gap_cnt;
   logic                     high_phase;
   logic                     held_full;
   logic                     held_last;
   logic                     sending_last;
   logic                     framing;
   rsp_type                  line_expect_q[$];
   int                       fail_tally;

   task automatic start_bit();
      high_phase = 1'b1;
      phase_cnt  = shifter[PIXEL_BITS-1] ? timing.one_high_ticks : timing.zero_high_ticks;
   endtask

   task automatic load_pixel();
      shifter      = held_grb;
      sending_last = held_last;
      held_full    = 1'b0;
      bits_left    = BITS_PER_PIXEL;
      framing      = 1'b1;
      start_bit();
   endtask

   // One beat of the encoder: an offer fills the buffer, a tick moves the line.
   task automatic advance_line(input req_type beat, output rsp_type level);
      logic refused;
      logic underrun;
      refused  = 1'b0;
      underrun = 1'b0;
      if (beat.cmd == CMD_OFFER) begin
         if (held_full) begin
            refused = 1'b1;
         end else begin
            held_grb  = {beat.green, beat.red, beat.blue};
            held_last = beat.frame_last;
            held_full = 1'b1;
         end
      end else if (bits_left == '0) begin
         if (framing) begin
            if (held_full) load_pixel();
         end else if (held_full &&
                      (gap_cnt >= timing.latch_ticks || gap_cnt == GAP_SATURATED)) begin
            load_pixel();
         end else if (gap_cnt != GAP_SATURATED) begin
            gap_cnt = gap_cnt + 1'b1;
         end
      end else if (phase_cnt > 1) begin
         phase_cnt = phase_cnt - 1'b1;
      end else if (high_phase) begin
         high_phase = 1'b0;
         phase_cnt  = shifter[PIXEL_BITS-1] ? timing.one_low_ticks : timing.zero_low_ticks;
      end else begin
         shifter   = shifter << 1;
         bits_left = bits_left - 1'b1;
         if (bits_left != '0) begin
            start_bit();
         end else begin
            high_phase = 1'b0;
            phase_cnt  = '0;
            if (sending_last) begin
               framing = 1'b0;
               gap_cnt = '0;
            end else if (held_full) begin
               load_pixel();
            end else begin
               underrun = 1'b1;
            end
         end
      end
      level.line_level = (bits_left != '0) && high_phase;
      level.can_accept = !held_full;
      level.refused    = refused;
      level.underrun   = underrun;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         timing.zero_high_ticks = RST_ZERO_HIGH;
         timing.zero_low_ticks  = RST_ZERO_LOW;
         timing.one_high_ticks  = RST_ONE_HIGH;
         timing.one_low_ticks   = RST_ONE_LOW;
         timing.latch_ticks     = RST_LATCH;
         shifter      = '0;
         held_grb     = '0;
         bits_left    = '0;
         phase_cnt    = '0;
         gap_cnt      = GAP_SATURATED;
         high_phase   = 1'b0;
         held_full    = 1'b0;
         held_last    = 1'b0;
         sending_last = 1'b0;
         framing      = 1'b0;
         line_expect_q.delete();
         fail_tally   = 0;
      end else begin
         // results first, so a beat never meets its own prediction
         if (rsp_fire) begin
            if (line_expect_q.size() == 0) begin
               if (fail_tally < REPORT_LIMIT)
                  $display("%0t: ERROR unexpected result beat: line %0b accept %0b refused %0b underrun %0b",
                           $time, rsp_beat.line_level, rsp_beat.can_accept,
                           rsp_beat.refused, rsp_beat.underrun);
               fail_tally++;
            end else begin
               want = line_expect_q.pop_front();
               if (rsp_beat !== want) begin
                  if (fail_tally < REPORT_LIMIT)
                     $display("%0t: ERROR result beat: line %0b/%0b accept %0b/%0b refused %0b/%0b underrun %0b/%0b (exp/got)",
                              $time, want.line_level, rsp_beat.line_level,
                              want.can_accept, rsp_beat.can_accept,
                              want.refused, rsp_beat.refused,
                              want.underrun, rsp_beat.underrun);
                  fail_tally++;
               end
            end
         end
         if (req_fire) begin
            advance_line(req_beat, want);
            line_expect_q.push_back(want);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ZERO_HIGH: timing.zero_high_ticks = csr_wdata;
               CSR_ZERO_LOW:  timing.zero_low_ticks  = csr_wdata;
               CSR_ONE_HIGH:  timing.one_high_ticks  = csr_wdata;
               CSR_ONE_LOW:   timing.one_low_ticks   = csr_wdata;
               CSR_LATCH:     timing.latch_ticks     = csr_wdata;
               default: ;
            endcase
         end
      end
      mismatch_count <= fail_tally;
      open_count     <= line_expect_q.size();
   end

endmodule

/* test/rgb_led_serial_pulse_encoder_tb.sv */
// Testbench top for the pulse encoder: stimulus, handshake idling, watchdog and verdict.
module rgb_led_serial_pulse_encoder_tb;
   import rlpe_pkg::*;

   // Longest beat-free stretch of a correct run is the receiver hold-off plus
   // the pipeline settling; the limit leaves a wide margin over that.
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   // Two register stages between req and rsp; the settle wait covers both.
   localparam int SETTLE_CYCLES   = 4;
   localparam int BEATS_PER_PHASE = 30;
   localparam logic [CSR_DATA_BITS-1:0] TIMER_TOP = '1;

   logic clock = 1'b0;
   logic reset;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rlpe_chan_if #(.payload_type(req_type)) req_bus ();
   rlpe_chan_if #(.payload_type(rsp_type)) rsp_bus ();

   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   int   mismatches;
   int   in_flight;
   int   tx_idle_pct;
   int   rx_stall_pct;
   logic hold_kick;
   int   beats_sent = 0;
   int   quiet_cycles = 0;

   // Stimulus-side copy of the timing registers, only used to pace frames.
   logic [CSR_DATA_BITS-1:0] zh_t, zl_t, oh_t, ol_t, latch_t;

   rgb_led_serial_pulse_encoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rlpe_line_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_bus.valid && req_bus.ready),
      .req_beat       (req_bus.payload),
      .rsp_fire       (rsp_bus.valid && rsp_bus.ready),
      .rsp_beat       (rsp_bus.payload),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .open_count     (in_flight)
   );

   // Receiver: random stalls, plus a long hold-off on request so the encoder
   // backs up and pushes back on req.
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_kick) hold_left = HOLD_OFF_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // Watchdog: counts cycles with no beat on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_beat(input logic cmd, input logic [PIXEL_BITS-1:0] grb,
                                         input logic last);
      req_type beat;
      beat.cmd        = cmd;
      beat.green      = grb[23:16];
      beat.red        = grb[15:8];
      beat.blue       = grb[7:0];
      beat.frame_last = last;
      return beat;
   endfunction

   // Bytes lean toward the all-zero and all-one extremes now and then.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [PIXEL_BITS-1:0] pick_pixel();
      return {pick_byte(), pick_byte(), pick_byte()};
   endfunction

   // A programmed length of zero behaves as one tick.
   function automatic int phase_len(input logic [CSR_DATA_BITS-1:0] ticks);
      return (ticks == '0) ? 1 : int'(ticks);
   endfunction

   function automatic int pixel_ticks(input logic [PIXEL_BITS-1:0] grb);
      int total;
      total = 0;
      for (int i = 0; i < PIXEL_BITS; i++)
         total += grb[i] ? phase_len(oh_t) + phase_len(ol_t)
                         : phase_len(zh_t) + phase_len(zl_t);
      return total;
   endfunction

   // Drive one beat and return at the edge that accepts it. Valid is left
   // high; the next call either keeps it up or drops it for an idle gap.
   task automatic push_beat(input req_type beat);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= beat;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
   endtask

   // Tick beats carry random junk in the pixel fields; the encoder ignores it.
   task automatic run_ticks(input int count);
      repeat (count) push_beat(make_beat(CMD_TICK, 24'($urandom), 1'($urandom)));
   endtask

   task automatic offer_pixel(input logic [PIXEL_BITS-1:0] grb, input logic last);
      push_beat(make_beat(CMD_OFFER, grb, last));
   endtask

   task automatic run_noise(input int count);
      repeat (count)
         push_beat(make_beat($urandom_range(1) ? CMD_OFFER : CMD_TICK,
                             24'($urandom), 1'($urandom)));
   endtask

   // Wait until every result is back, then let the pipeline settle.
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_ZERO_HIGH: zh_t    = val;
         CSR_ZERO_LOW:  zl_t    = val;
         CSR_ONE_HIGH:  oh_t    = val;
         CSR_ONE_LOW:   ol_t    = val;
         CSR_LATCH:     latch_t = val;
         default: ;
      endcase
   endtask

   // Full timing update while idle; one write past the last register must be dropped.
   task automatic program_timing(input logic [CSR_DATA_BITS-1:0] zh, zl, oh, ol, latch);
      quiesce();
      write_reg(CSR_ZERO_HIGH, zh);
      write_reg(CSR_ZERO_LOW, zl);
      write_reg(CSR_ONE_HIGH, oh);
      write_reg(CSR_ONE_LOW, ol);
      write_reg(CSR_LATCH, latch);
      write_reg(CSR_LATCH + 3'(1 + $urandom_range(2)), 16'($urandom));
      csr_we <= 1'b0;
   endtask

   // A frame paced so each next pixel arrives right after the previous one
   // loads. A sloppy frame skews the pacing (refusals, underruns) and throws
   // in stray offers.
   task automatic run_frame(input int n_px, input bit sloppy);
      logic [PIXEL_BITS-1:0] prev;
      logic [PIXEL_BITS-1:0] px;
      int                    skew;
      px = pick_pixel();
      offer_pixel(px, n_px == 1);
      run_ticks(1);
      for (int i = 1; i < n_px; i++) begin
         prev = px;
         px   = pick_pixel();
         offer_pixel(px, i == n_px - 1);
         skew = sloppy ? int'($urandom_range(4)) - 2 : 0;
         run_ticks(pixel_ticks(prev) + skew);
         if (sloppy && $urandom_range(3) == 0) offer_pixel(pick_pixel(), 1'($urandom));
      end
      // last pixel, then the latch gap plus a little slack
      run_ticks(pixel_ticks(px) + int'(latch_t) + int'($urandom_range(2)));
   endtask

   task automatic random_phase(input int tx_pct, input int rx_pct, input bit squeeze);
      int stop_at;
      program_timing(16'($urandom_range(2)), 16'($urandom_range(2)),
                     16'($urandom_range(2)), 16'($urandom_range(2)),
                     16'($urandom_range(10)));
      tx_idle_pct = tx_pct;
      rx_stall_pct <= rx_pct;
      if (squeeze) begin
         hold_kick <= 1'b1;
         @(posedge clock);
         hold_kick <= 1'b0;
      end
      stop_at = beats_sent + BEATS_PER_PHASE;
      while (beats_sent < stop_at) begin
         case ($urandom_range(9))
            0:       run_noise(1 + $urandom_range(5));
            1, 2:    run_frame(1 + $urandom_range(1), 1'b1);
            default: run_frame(1 + $urandom_range(1), 1'b0);
         endcase
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_ZERO_HIGH;
      csr_wdata       <= '0;
      hold_kick       <= 1'b0;
      rx_stall_pct    <= 0;
      tx_idle_pct      = 0;
      zh_t    = RST_ZERO_HIGH;
      zl_t    = RST_ZERO_LOW;
      oh_t    = RST_ONE_HIGH;
      ol_t    = RST_ONE_LOW;
      latch_t = RST_LATCH;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset timing: idle tick with the latch gap already met,
      // then an offer into an empty buffer and one into a full buffer.
      run_ticks(1);
      offer_pixel({8'h80, 8'hFF, 8'h00}, 1'b0);
      offer_pixel({8'h00, 8'h00, 8'hFF}, 1'b1);
      // First tick starts the frame; a one bit holds high 40 ticks, then goes low.
      run_ticks(44);

      // Zero phase lengths and a zero latch gap. The pixel in flight finishes
      // on the new timing and, with nothing buffered, underruns mid-frame.
      program_timing(16'd0, 16'd1, 16'd2, 16'd0, 16'd0);
      run_ticks(100);
      // Open frame after underrun: next pixel loads without a latch wait.
      offer_pixel({8'hFF, 8'hFF, 8'hFF}, 1'b1);
      run_ticks(1 + pixel_ticks(24'hFFFFFF));
      offer_pixel(24'h000000, 1'b1);
      run_ticks(2 + pixel_ticks(24'h000000));

      // Random part: free flow with a long receiver hold-off first, then
      // sender idling, receiver stalling, and both.
      random_phase(0, 0, 1'b1);
      random_phase(79, 0, 1'b0);
      random_phase(0, 79, 1'b0);
      random_phase(33, 33, 1'b0);

      // Extremes: a short frame, then a full-range latch gap.
      tx_idle_pct = 0;
      rx_stall_pct <= 0;
      program_timing(16'd1, 16'd1, 16'd2, 16'd1, 16'd1);
      offer_pixel(24'h800000, 1'b1);
      run_ticks(1 + pixel_ticks(24'h800000));
      // Gap far below the latch: the pixel stays buffered, a second is refused.
      program_timing(16'd1, 16'd1, 16'd2, 16'd1, TIMER_TOP);
      offer_pixel(24'h000000, 1'b1);
      run_ticks(20);
      offer_pixel(pick_pixel(), 1'b0);
      // Shorter latch takes effect on the next tick; the held pixel goes out.
      program_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      run_ticks(3 + pixel_ticks(24'h000000));

      quiesce();
      if (mismatches == 0 && in_flight == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
